[rtl/core/dtmr_pkg.sv]
// Shared types, register codes and constants for the dual down-counter timer.
`timescale 1ns / 1ps
`default_nettype none

package dtmr_pkg;

  // Default counter width.
  localparam int unsigned CounterBitsDefault = 32;

  // Request modes.
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeWrite = 2'd2;

  // Register word index inside one counter's frame (offset bits 4..2).
  localparam logic [2:0] RegLoad   = 3'd0;
  localparam logic [2:0] RegValue  = 3'd1;
  localparam logic [2:0] RegCtrl   = 3'd2;
  localparam logic [2:0] RegIntClr = 3'd3;
  localparam logic [2:0] RegRis    = 3'd4;
  localparam logic [2:0] RegMis    = 3'd5;
  localparam logic [2:0] RegBgLoad = 3'd6;

  // Control register bit positions.
  localparam int unsigned CtlOneShot  = 0;
  localparam int unsigned CtlSize32   = 1;
  localparam int unsigned CtlIntEn    = 5;
  localparam int unsigned CtlPeriodic = 6;
  localparam int unsigned CtlEnable   = 7;

  // Offset bit that selects the second counter.
  localparam int unsigned SecondSelBit = 5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  offset;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_first;
    logic        irq_second;
  } out_t;

  // Per-counter request from the top level.
  typedef struct packed {
    logic        tick;
    logic        wr;
    logic [2:0]  reg_sel;
    logic [31:0] wdata;
  } cnt_req_t;

  // Per-counter status back to the top level.
  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_next;
  } cnt_sts_t;

endpackage

`default_nettype wire

[rtl/core/dtmr_counter.sv]
// One down-counter with its load, control, status and background-load registers.
`timescale 1ns / 1ps
`default_nettype none

module dtmr_counter #(
  parameter int unsigned COUNTER_BITS = dtmr_pkg::CounterBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dtmr_pkg::cnt_req_t req_i,
  output dtmr_pkg::cnt_sts_t      sts_o
);

  localparam logic [COUNTER_BITS-1:0] FullMask  = '1;
  localparam logic [COUNTER_BITS-1:0] HalfMask  = FullMask >> (COUNTER_BITS - 16);

  logic [COUNTER_BITS-1:0] reload_q, reload_d;
  logic [COUNTER_BITS-1:0] count_q, count_d;
  logic [7:0]              ctrl_q, ctrl_d;
  logic                    raw_q, raw_d;

  logic [COUNTER_BITS-1:0] act_mask;
  logic [COUNTER_BITS-1:0] cur;
  logic [COUNTER_BITS-1:0] dec;
  logic [COUNTER_BITS-1:0] wval;

  assign act_mask = ctrl_q[dtmr_pkg::CtlSize32] ? FullMask : HalfMask;
  assign cur      = count_q & act_mask;
  assign dec      = (cur - 1'b1) & act_mask;
  assign wval     = req_i.wdata[COUNTER_BITS-1:0];

  always_comb begin
    reload_d = reload_q;
    count_d  = count_q;
    ctrl_d   = ctrl_q;
    raw_d    = raw_q;
    if (req_i.tick && ctrl_q[dtmr_pkg::CtlEnable]) begin
      if (cur == '0) begin
        // At zero the counter halts, reloads or wraps depending on mode.
        if (ctrl_q[dtmr_pkg::CtlOneShot]) begin
          count_d = '0;
        end else if (ctrl_q[dtmr_pkg::CtlPeriodic]) begin
          count_d = reload_q & act_mask;
          if ((reload_q & act_mask) == '0) begin
            raw_d = 1'b1;
          end
        end else begin
          count_d = act_mask;
        end
      end else begin
        count_d = dec;
        if (dec == '0) begin
          raw_d = 1'b1;
        end
      end
    end else if (req_i.wr) begin
      case (req_i.reg_sel)
        dtmr_pkg::RegLoad: begin
          reload_d = wval;
          count_d  = wval;
          if (wval == '0) begin
            raw_d = 1'b1;
          end
        end
        dtmr_pkg::RegCtrl:   ctrl_d   = req_i.wdata[7:0];
        dtmr_pkg::RegIntClr: raw_d    = 1'b0;
        dtmr_pkg::RegBgLoad: reload_d = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (req_i.reg_sel)
      dtmr_pkg::RegLoad,
      dtmr_pkg::RegBgLoad: sts_o.rdata = 32'(reload_q);
      dtmr_pkg::RegValue:  sts_o.rdata = 32'(count_q);
      dtmr_pkg::RegCtrl:   sts_o.rdata = {24'd0, ctrl_q};
      dtmr_pkg::RegRis:    sts_o.rdata = {31'd0, raw_q};
      dtmr_pkg::RegMis:    sts_o.rdata = {31'd0, raw_q & ctrl_q[dtmr_pkg::CtlIntEn]};
      default:             sts_o.rdata = 32'd0;
    endcase
    sts_o.irq_next = raw_d & ctrl_d[dtmr_pkg::CtlIntEn];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      count_q  <= '1;
      ctrl_q   <= 8'd0;
      raw_q    <= 1'b0;
    end else begin
      reload_q <= reload_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      raw_q    <= raw_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dual_down_counter_timer.sv]
// Top level of the dual down-counter timer with its request and result registers.
// A request is registered in the input register on acceptance; its result is registered
// in the result register when the request leaves the input register.
// Throughput: one request per cycle while the output does not stall; the counters update in
// the cycle the request leaves the input register, so ticks can arrive back to back.
// A full result register with the output stalled holds one more request in the input register.
// Reset: counts go to all ones, reload values, control and raw interrupts to zero.
`timescale 1ns / 1ps
`default_nettype none

module dual_down_counter_timer #(
  parameter int unsigned COUNTER_BITS = dtmr_pkg::CounterBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dtmr_pkg::in_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dtmr_pkg::out_t     out_rsp_o
);

  logic           s1_valid_q, s1_valid_d;
  dtmr_pkg::in_t  s1_req_q;
  logic           out_valid_q, out_valid_d;
  dtmr_pkg::out_t out_rsp_q;
  dtmr_pkg::out_t out_rsp_d;

  logic s1_fire;
  logic in_fire;
  logic sel_second;

  dtmr_pkg::cnt_req_t req_first, req_second;
  dtmr_pkg::cnt_sts_t sts_first, sts_second;

  // The input register drains when the result register is empty or being taken.
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign sel_second = s1_req_q.offset[dtmr_pkg::SecondSelBit];

  always_comb begin
    req_first.tick    = s1_fire && (s1_req_q.mode == dtmr_pkg::ModeTick);
    req_first.wr      = s1_fire && (s1_req_q.mode == dtmr_pkg::ModeWrite) && !sel_second;
    req_first.reg_sel = s1_req_q.offset[4:2];
    req_first.wdata   = s1_req_q.write_data;
    req_second        = req_first;
    req_second.wr     = s1_fire && (s1_req_q.mode == dtmr_pkg::ModeWrite) && sel_second;
  end

  dtmr_counter #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_cnt_first (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_first),
    .sts_o (sts_first)
  );

  dtmr_counter #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_cnt_second (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_second),
    .sts_o (sts_second)
  );

  always_comb begin
    out_rsp_d.read_data  = 32'd0;
    if (s1_req_q.mode == dtmr_pkg::ModeRead) begin
      out_rsp_d.read_data = sel_second ? sts_second.rdata : sts_first.rdata;
    end
    out_rsp_d.irq_first  = sts_first.irq_next;
    out_rsp_d.irq_second = sts_second.irq_next;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= in_req_i;
    end
    if (s1_fire) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

[bench/dtmr_rsp_checker.sv]
// Checker for the dual down-counter timer: predicts each response and compares it.
`timescale 1ns / 1ps

module dtmr_rsp_checker
  import dtmr_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = CounterBitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_stall_i,
  input  wire in_t   in_req_i,
  input  wire logic  out_valid_i,
  input  wire logic  out_stall_i,
  input  wire out_t  out_rsp_i,
  output int unsigned fail_count_o = 0,
  output int unsigned pending_o = 0
);

  localparam logic [31:0] WideMask = 32'((64'd1 << COUNTER_BITS) - 64'd1);

  logic [31:0] reload_q [2];
  logic [31:0] count_q  [2];
  logic [7:0]  ctl_q    [2];
  logic        raw_q    [2];

  out_t expected_rsp_q [$];

  function automatic logic [31:0] span_mask(input int k);
    return ctl_q[k][CtlSize32] ? WideMask : (WideMask & 32'h0000_FFFF);
  endfunction

  function automatic logic masked_irq(input int k);
    return raw_q[k] & ctl_q[k][CtlIntEn];
  endfunction

  function automatic void advance_counter(input int k);
    logic [31:0] m;
    logic [31:0] c;
    if (!ctl_q[k][CtlEnable]) return;
    m = span_mask(k);
    c = count_q[k] & m;
    if (c == '0) begin
      // At zero the counter halts, reloads or wraps, depending on its mode.
      if (ctl_q[k][CtlOneShot]) c = '0;
      else if (ctl_q[k][CtlPeriodic]) c = reload_q[k] & m;
      else c = m;
      count_q[k] = c;
      if (c == '0 && !ctl_q[k][CtlOneShot]) raw_q[k] = 1'b1;
    end else begin
      c = (c - 32'd1) & m;
      count_q[k] = c;
      if (c == '0) raw_q[k] = 1'b1;
    end
  endfunction

  function automatic out_t predict_timer_rsp(input in_t req);
    out_t        rsp;
    int          k;
    logic [2:0]  sel;
    logic [31:0] wdata;
    k     = req.offset[SecondSelBit] ? 1 : 0;
    sel   = req.offset[4:2];
    wdata = req.write_data & WideMask;
    rsp   = '0;
    case (req.mode)
      ModeTick: begin
        advance_counter(0);
        advance_counter(1);
      end
      ModeRead: begin
        case (sel)
          RegLoad, RegBgLoad: rsp.read_data = reload_q[k];
          RegValue:           rsp.read_data = count_q[k];
          RegCtrl:            rsp.read_data = {24'd0, ctl_q[k]};
          RegRis:             rsp.read_data = {31'd0, raw_q[k]};
          RegMis:             rsp.read_data = {31'd0, masked_irq(k)};
          default:            rsp.read_data = '0;
        endcase
      end
      ModeWrite: begin
        case (sel)
          RegLoad: begin
            reload_q[k] = wdata;
            count_q[k]  = wdata;
            if (wdata == '0) raw_q[k] = 1'b1;
          end
          RegCtrl:   ctl_q[k] = req.write_data[7:0];
          RegIntClr: raw_q[k] = 1'b0;
          RegBgLoad: reload_q[k] = wdata;
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.irq_first  = masked_irq(0);
    rsp.irq_second = masked_irq(1);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        reload_q[k] = '0;
        count_q[k]  = WideMask;
        ctl_q[k]    = '0;
        raw_q[k]    = 1'b0;
      end
      expected_rsp_q.delete();
      pending_o = 0;
    end else begin
      // A response leaves only after its request has passed the input and result registers, so check it first.
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp_i.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_rsp_i.read_data);
            fail_count_o++;
          end
          if (out_rsp_i.irq_first !== want.irq_first) begin
            $error("irq_first: expected %b, got %b", want.irq_first, out_rsp_i.irq_first);
            fail_count_o++;
          end
          if (out_rsp_i.irq_second !== want.irq_second) begin
            $error("irq_second: expected %b, got %b", want.irq_second, out_rsp_i.irq_second);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(predict_timer_rsp(in_req_i));
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

[bench/tb_dual_down_counter_timer.sv]
// Testbench top for the dual down-counter timer: request stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_dual_down_counter_timer;
  import dtmr_pkg::*;

  localparam int unsigned CounterBits = CounterBitsDefault;
  localparam int unsigned LimitCycles = 300000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseItems  = 400;

  localparam logic [1:0] ModeUnused  = 2'd3;
  localparam logic [2:0] RegReserved = 3'd7;

  localparam logic [31:0] CtlOneShotBit  = 32'd1 << CtlOneShot;
  localparam logic [31:0] CtlSize32Bit   = 32'd1 << CtlSize32;
  localparam logic [31:0] CtlIntEnBit    = 32'd1 << CtlIntEn;
  localparam logic [31:0] CtlPeriodicBit = 32'd1 << CtlPeriodic;
  localparam logic [31:0] CtlEnableBit   = 32'd1 << CtlEnable;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_req    = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_rsp;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dual_down_counter_timer #(
    .COUNTER_BITS(CounterBits)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  dtmr_rsp_checker #(
    .COUNTER_BITS(CounterBits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [5:0] reg_off(input logic k, input logic [2:0] sel);
    return {k, sel, 2'b00};
  endfunction

  task automatic send_request(input logic [1:0] mode, input logic [5:0] off,
                              input logic [31:0] data);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_req   <= '{mode: mode, offset: off, write_data: data};
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly short load/control/tick sequences so counters really reach zero.
  task automatic send_random_request(output logic counted);
    int unsigned pick;
    logic        k;
    logic [2:0]  sel;
    logic [31:0] data;
    pick    = $urandom_range(99);
    k       = 1'($urandom_range(1));
    data    = $urandom;
    counted = 1'b1;
    if (pick < 45) begin
      send_request(ModeTick, 6'($urandom), data);
    end else if (pick < 65) begin
      send_request(ModeRead, 6'($urandom), data);
    end else if (pick < 96) begin
      case ($urandom_range(9))
        0, 1, 2: sel = RegLoad;
        3, 4:    sel = RegCtrl;
        5:       sel = RegIntClr;
        6, 7:    sel = RegBgLoad;
        default: sel = 3'($urandom);
      endcase
      if (sel == RegLoad || sel == RegBgLoad) begin
        if ($urandom_range(3) != 0) begin
          data = $urandom_range(12);
          if ($urandom_range(2) == 0) data[31:16] = 16'($urandom);
        end
      end else if (sel == RegCtrl) begin
        if ($urandom_range(4) != 0) data[CtlEnable] = 1'b1;
      end
      send_request(ModeWrite, {k, sel, 2'($urandom)}, data);
    end else begin
      counted = 1'b0;
      send_request(ModeUnused, 6'($urandom), data);
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned done;
    logic        counted;
    done = 0;
    while (done < n) begin
      send_random_request(counted);
      if (counted) done++;
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct  = 6;
    stall_pct = 85;

    // Load of zero raises the interrupt at once; periodic reload of zero keeps it raised.
    send_request(ModeRead, reg_off(1'b0, RegValue), 32'd0);
    send_request(ModeWrite, reg_off(1'b0, RegLoad), 32'd0);
    send_request(ModeRead, reg_off(1'b0, RegRis), 32'd0);
    send_request(ModeWrite, reg_off(1'b0, RegCtrl),
                 CtlEnableBit | CtlIntEnBit | CtlPeriodicBit | CtlSize32Bit);
    send_request(ModeTick, 6'h00, 32'd0);
    send_request(ModeWrite, reg_off(1'b0, RegIntClr), 32'hFFFF_FFFF);
    send_request(ModeTick, 6'h3F, 32'hFFFF_FFFF);
    send_request(ModeRead, reg_off(1'b0, RegMis), 32'd0);
    // Second counter: unaligned offset, 16-bit count, one-shot wins over periodic.
    send_request(ModeWrite, reg_off(1'b1, RegLoad) | 6'd3, 32'h0001_0002);
    send_request(ModeWrite, reg_off(1'b1, RegCtrl),
                 CtlEnableBit | CtlIntEnBit | CtlOneShotBit | CtlPeriodicBit);
    repeat (3) send_request(ModeTick, 6'h00, 32'd0);
    send_request(ModeRead, reg_off(1'b1, RegValue), 32'd0);
    send_request(ModeWrite, reg_off(1'b1, RegBgLoad), 32'hFFFF_FFFF);
    send_request(ModeRead, reg_off(1'b1, RegLoad), 32'd0);
    send_request(ModeRead, reg_off(1'b1, RegBgLoad) | 6'd1, 32'd0);
    // Writes to read-only and reserved words, reads of write-only and reserved words.
    send_request(ModeWrite, reg_off(1'b1, RegValue), 32'h0000_1234);
    send_request(ModeWrite, reg_off(1'b1, RegRis), 32'd0);
    send_request(ModeWrite, reg_off(1'b1, RegReserved), 32'hFFFF_FFFF);
    send_request(ModeRead, reg_off(1'b1, RegIntClr), 32'd0);
    send_request(ModeRead, reg_off(1'b1, RegReserved), 32'd0);
    send_request(ModeUnused, 6'h3F, 32'hFFFF_FFFF);
    // Free-running 16-bit counter wraps to all ones after reaching zero.
    send_request(ModeWrite, reg_off(1'b0, RegCtrl), CtlEnableBit);
    send_request(ModeWrite, reg_off(1'b0, RegLoad), 32'd1);
    repeat (2) send_request(ModeTick, 6'h00, 32'd0);
    send_request(ModeRead, reg_off(1'b0, RegValue), 32'd0);

    run_random(PhaseItems);
    idle_pct  = 85;
    stall_pct = 6;
    run_random(PhaseItems);
    idle_pct  = 0;
    stall_pct = 0;
    run_random(PhaseItems);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS dual_down_counter_timer");
    end else begin
      $display("FAIL dual_down_counter_timer");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL dual_down_counter_timer");
    $finish;
  end

endmodule
